/* sv/sctc_pkg.sv */
package sctc_pkg;

	localparam int ENTRIES      = 32;
	localparam int LINE_SECTORS = 8;
	localparam int UNIT_COUNT   = 8;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int UNIT_W = 3;
	localparam int POS_W  = 32;

	typedef enum logic [2:0] {
		CMD_READ     = 3'd0,
		CMD_WRITE    = 3'd1,
		CMD_FILL_OK  = 3'd2,
		CMD_FILL_BAD = 3'd3,
		CMD_INV_UNIT = 3'd4,
		CMD_INV_ALL  = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic [POS_W-1:0]  base;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	function automatic logic [4:0] to_entry_index(logic [IDX_W-1:0] i);
		logic [IDX_W+4:0] t;
		t = (IDX_W + 5)'(i);
		return t[4:0];
	endfunction

endpackage

/* sv/sctc_req_if.sv */
interface sctc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [2:0]  unit;
	logic [31:0] sector_pos;
	logic        media_changed;

	modport source (output valid, command, unit, sector_pos, media_changed, input ready);
	modport sink (input valid, command, unit, sector_pos, media_changed, output ready);
endinterface

/* sv/sctc_rsp_if.sv */
interface sctc_rsp_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic [4:0] entry_index;
	logic [2:0] line_offset;
	logic       need_fill;

	modport source (output valid, hit, entry_index, line_offset, need_fill, input ready);
	modport sink (input valid, hit, entry_index, line_offset, need_fill, output ready);
endinterface

/* sv/sector_cache_tag_controller.sv */
// Tag controller of a fully associative sector cache with round-robin
// replacement. A read or write lookup, and a unit invalidation, walks the tag
// RAM one entry per cycle through its single read port and one shared
// subtract-and-compare unit: a lookup ends at its first hit or after the last
// entry, an invalidation or a media-changed lookup after the last one. Fill
// ok, fill failed, invalidate all, unused commands and units out of range
// answer in the cycle after acceptance. One request is in flight at a time:
// the next is accepted once the response has been taken. Valid marks live in
// flip-flops cleared by reset, so there is no clearing pass after reset.
module sector_cache_tag_controller import sctc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sctc_req_if.sink    req,
	sctc_rsp_if.source  rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	state_t             state_q;
	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   victim_q;
	logic [UNIT_W-1:0]  pend_unit_q;
	logic [POS_W-1:0]   pend_pos_q;

	logic               is_read_q;
	logic               is_lookup_q;
	logic               drop_q;
	logic [UNIT_W-1:0]  unit_q;
	logic [POS_W-1:0]   pos_q;

	logic               issue_q;
	logic [IDX_W-1:0]   addr_q;
	logic               chk_v_s1;
	logic [IDX_W-1:0]   chk_idx_s1;

	logic               res_valid_q;
	logic               res_hit_q;
	logic [4:0]         res_idx_q;
	logic [2:0]         res_off_q;
	logic               res_fill_q;

	logic               accept;
	logic               unit_ok;
	logic               ram_we;
	entry_t             ram_wdata;
	entry_t             ram_rdata;
	logic [POS_W:0]     diff;
	logic               ent_match;
	logic               covered;
	logic               found;
	logic               last_chk;

	assign req.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign accept    = req.valid && req.ready;
	assign unit_ok   = ({1'b0, req.unit} < 4'(UNIT_COUNT));

	assign ram_we          = accept && (req.command == CMD_FILL_OK);
	assign ram_wdata.unit  = pend_unit_q;
	assign ram_wdata.base  = pend_pos_q;

	sctc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTRIES)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(victim_q),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	assign diff      = {1'b0, pos_q} - {1'b0, ram_rdata.base};
	assign covered   = !diff[POS_W] && (diff[POS_W-1:0] < POS_W'(LINE_SECTORS));
	assign ent_match = valid_q[chk_idx_s1] && (ram_rdata.unit == unit_q);
	assign found     = chk_v_s1 && !drop_q && ent_match && covered;
	assign last_chk  = chk_v_s1 && (chk_idx_s1 == LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			victim_q    <= '0;
			pend_unit_q <= '0;
			pend_pos_q  <= '0;
			issue_q     <= 1'b0;
			chk_v_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.command)
							CMD_READ, CMD_WRITE, CMD_INV_UNIT: begin
								if (unit_ok) begin
									state_q  <= ST_SCAN;
									issue_q  <= 1'b1;
									chk_v_s1 <= 1'b0;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							CMD_FILL_OK: begin
								valid_q[victim_q] <= 1'b1;
								victim_q          <= (victim_q == LAST) ? '0 : victim_q + 1'b1;
								res_valid_q       <= 1'b1;
							end
							CMD_FILL_BAD: begin
								valid_q[victim_q] <= 1'b0;
								res_valid_q       <= 1'b1;
							end
							CMD_INV_ALL: begin
								valid_q     <= '0;
								res_valid_q <= 1'b1;
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (chk_v_s1 && drop_q && ent_match) begin
						valid_q[chk_idx_s1] <= 1'b0;
					end
					if (found || last_chk) begin
						state_q     <= ST_IDLE;
						issue_q     <= 1'b0;
						chk_v_s1    <= 1'b0;
						res_valid_q <= 1'b1;
						if (!found && is_read_q) begin
							pend_unit_q <= unit_q;
							pend_pos_q  <= pos_q;
						end
					end else begin
						chk_v_s1 <= issue_q;
						if (issue_q && addr_q == LAST) begin
							issue_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_q   <= (req.command == CMD_READ);
			is_lookup_q <= (req.command == CMD_READ) || (req.command == CMD_WRITE);
			drop_q      <= (req.command == CMD_INV_UNIT) || req.media_changed;
			unit_q      <= req.unit;
			pos_q       <= req.sector_pos;
			addr_q      <= '0;
			res_hit_q   <= 1'b0;
			res_idx_q   <= '0;
			res_off_q   <= '0;
			res_fill_q  <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			chk_idx_s1 <= addr_q;
			if (issue_q) begin
				addr_q <= addr_q + 1'b1;
			end
			if (found) begin
				res_hit_q <= 1'b1;
				res_idx_q <= to_entry_index(chk_idx_s1);
				res_off_q <= diff[2:0];
			end else if (last_chk && is_read_q && is_lookup_q) begin
				res_idx_q  <= to_entry_index(victim_q);
				res_fill_q <= 1'b1;
			end
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.hit         = res_hit_q;
	assign rsp.entry_index = res_idx_q;
	assign rsp.line_offset = res_off_q;
	assign rsp.need_fill   = res_fill_q;

endmodule

/* sv/sctc_ram.sv */
module sctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/sctc_checker.sv */
module sctc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_hit,
	input logic [4:0] rsp_entry_index,
	input logic [2:0] rsp_line_offset,
	input logic       rsp_need_fill
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
			&& $stable(rsp_entry_index) && $stable(rsp_line_offset)
			&& $stable(rsp_need_fill))
		else $error("response changed while stalled");

	a_fill_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_need_fill |-> !rsp_hit && rsp_line_offset == 3'd0)
		else $error("fill request on a hit");

	a_miss_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_line_offset == 3'd0)
		else $error("offset on a miss");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit && !rsp_need_fill |-> rsp_entry_index == 5'd0)
		else $error("entry index without hit or fill");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while one is in flight");

endmodule

bind sector_cache_tag_controller sctc_checker u_sctc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_entry_index(rsp.entry_index),
	.rsp_line_offset(rsp.line_offset),
	.rsp_need_fill  (rsp.need_fill)
);
